// ----- rtl/tfq_pkg.sv -----
package tfq_pkg;

    localparam int TAG_BITS = 8;
    localparam int COUNT_BITS = 8;
    localparam int LEVELS = 3;

    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_DEQUEUE = 1'b1;

    localparam logic [1:0] LEVEL_TOP = 2'd0;
    localparam logic [1:0] LEVEL_MIDDLE = 2'd1;
    localparam logic [1:0] LEVEL_BOTTOM = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                  mode;
        logic [TAG_BITS-1:0]   request_tag;
        logic [COUNT_BITS-1:0] served_count;
    } in_item_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] out_tag;
        logic                out_valid;
        logic [1:0]          out_level;
        logic [1:0]          status;
    } out_item_t;

endpackage

// ----- rtl/tfq_ram.sv -----
module tfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/three_level_feedback_queue.sv -----
// Three-level feedback queue of request tags.
//
// Input channel s_valid/s_ready/s_data carries one beat per operation. With
// mode enqueue, request_tag goes to the top queue for served_count 0, the
// middle queue for 1 and the bottom queue otherwise; a full queue drops the
// tag and reports status full. With mode dequeue, the oldest tag of the
// highest non-empty queue is popped; if all queues are empty the status says
// so. Every input beat yields exactly one result beat on m_valid/m_ready/m_data.
//
// An accepted beat loads stage 1 and the RAM read register, then the output
// register that drives m_data. Throughput is one beat per cycle unless m_ready
// stalls, set by the single registered read or write port of each level's tag
// RAM, which is used once per operation. A stalled m_ready holds the result and
// the stage behind it; s_ready drops only when both are full.
//
// Reset clears pointers, fill counts and both valid stages; all queues read as
// empty at once. RAM contents are not cleared.
module three_level_feedback_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tfq_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tfq_pkg::out_item_t  m_data
);

    localparam int STORE_W = (TAG_WIDTH < tfq_pkg::TAG_BITS) ? TAG_WIDTH : tfq_pkg::TAG_BITS;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LEV = tfq_pkg::LEVELS;

    logic [PTR_W-1:0] head_reg [LEV];
    logic [PTR_W-1:0] tail_reg [LEV];
    logic [CNT_W-1:0] count_reg [LEV];

    logic             s1_valid_reg;
    logic             s1_hit_reg;
    logic [1:0]       s1_level_reg;
    logic [1:0]       s1_status_reg;

    logic               m_valid_reg;
    tfq_pkg::out_item_t m_data_reg;

    logic             accept;
    logic             s1_advance;
    logic             is_enq;
    logic [1:0]       enq_level;
    logic [1:0]       deq_level;
    logic [1:0]       op_level;
    logic [1:0]       meta_level;
    logic [1:0]       meta_status;
    logic             deq_hit;
    logic             full;
    logic             push;
    logic             pop;
    logic [LEV-1:0]   nonempty;
    logic [LEV-1:0]   ram_we;
    logic [LEV-1:0]   ram_re;
    logic [STORE_W-1:0] ram_rdata [LEV];
    logic [STORE_W-1:0] wdata;
    logic [STORE_W-1:0] sel_rdata;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_advance;
    assign accept = s_valid && s_ready;
    assign is_enq = (s_data.mode == tfq_pkg::MODE_ENQUEUE);

    always_comb begin
        if (s_data.served_count == tfq_pkg::COUNT_BITS'(0)) begin
            enq_level = tfq_pkg::LEVEL_TOP;
        end else if (s_data.served_count == tfq_pkg::COUNT_BITS'(1)) begin
            enq_level = tfq_pkg::LEVEL_MIDDLE;
        end else begin
            enq_level = tfq_pkg::LEVEL_BOTTOM;
        end
    end

    always_comb begin
        for (int l = 0; l < LEV; l++) begin
            nonempty[l] = (count_reg[l] != '0);
        end
    end

    // Priority pick: top, then middle, then bottom.
    always_comb begin
        if (nonempty[0]) begin
            deq_level = tfq_pkg::LEVEL_TOP;
        end else if (nonempty[1]) begin
            deq_level = tfq_pkg::LEVEL_MIDDLE;
        end else begin
            deq_level = tfq_pkg::LEVEL_BOTTOM;
        end
    end

    assign deq_hit = |nonempty;
    assign full = (count_reg[enq_level] == CNT_W'(QUEUE_DEPTH));
    assign push = accept && is_enq && !full;
    assign pop = accept && !is_enq && deq_hit;
    assign op_level = is_enq ? enq_level : deq_level;
    assign wdata = s_data.request_tag[STORE_W-1:0];

    always_comb begin
        if (is_enq) begin
            meta_level = enq_level;
            meta_status = full ? tfq_pkg::STATUS_FULL : tfq_pkg::STATUS_OK;
        end else if (deq_hit) begin
            meta_level = deq_level;
            meta_status = tfq_pkg::STATUS_OK;
        end else begin
            meta_level = tfq_pkg::LEVEL_TOP;
            meta_status = tfq_pkg::STATUS_EMPTY;
        end
    end

    always_comb begin
        for (int l = 0; l < LEV; l++) begin
            ram_we[l] = push && (op_level == 2'(l));
            ram_re[l] = pop && (op_level == 2'(l));
        end
    end

    for (genvar g = 0; g < LEV; g++) begin : g_level
        tfq_ram #(
            .WIDTH (STORE_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we[g]),
            .waddr (tail_reg[g]),
            .wdata (wdata),
            .re    (ram_re[g]),
            .raddr (head_reg[g]),
            .rdata (ram_rdata[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < LEV; l++) begin
                head_reg[l] <= '0;
                tail_reg[l] <= '0;
                count_reg[l] <= '0;
            end
        end else begin
            for (int l = 0; l < LEV; l++) begin
                if (ram_we[l]) begin
                    tail_reg[l] <= next_ptr(tail_reg[l]);
                    count_reg[l] <= count_reg[l] + 1'b1;
                end
                if (ram_re[l]) begin
                    head_reg[l] <= next_ptr(head_reg[l]);
                    count_reg[l] <= count_reg[l] - 1'b1;
                end
            end
        end
    end

    // Stage 1 waits for the RAM read; hold it while the output is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_hit_reg <= pop;
            s1_level_reg <= meta_level;
            s1_status_reg <= meta_status;
        end
    end

    assign sel_rdata = (s1_level_reg == tfq_pkg::LEVEL_TOP)    ? ram_rdata[0] :
                       (s1_level_reg == tfq_pkg::LEVEL_MIDDLE) ? ram_rdata[1] :
                                                                 ram_rdata[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg) begin
            m_data_reg.out_tag <= s1_hit_reg ? tfq_pkg::TAG_BITS'(sel_rdata) : '0;
            m_data_reg.out_valid <= s1_hit_reg;
            m_data_reg.out_level <= s1_level_reg;
            m_data_reg.status <= s1_status_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

// ----- rtl/tfq_checker.sv -----
module tfq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input tfq_pkg::out_item_t m_data
);

    // Hold a stalled result beat.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_tag_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_valid |-> m_data.status == tfq_pkg::STATUS_OK)
        else $error("popped tag with error status");

    a_tag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_tag == '0)
        else $error("nonzero tag without pop");

    a_empty_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == tfq_pkg::STATUS_EMPTY
            |-> m_data.out_level == tfq_pkg::LEVEL_TOP && !m_data.out_valid)
        else $error("empty dequeue reports a level or a tag");

endmodule

bind three_level_feedback_queue tfq_checker u_tfq_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH = 8;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int MAX_GAP = 17;

    typedef struct {
        tfq_pkg::in_item_t  beat;
        int                 reps;
        bit                 known;
        tfq_pkg::out_item_t result;
    } directed_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    tfq_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    tfq_pkg::out_item_t m_data;

    // Shadow queues of the three priority levels
    logic [tfq_pkg::TAG_BITS-1:0] top_fifo[$];
    logic [tfq_pkg::TAG_BITS-1:0] middle_fifo[$];
    logic [tfq_pkg::TAG_BITS-1:0] bottom_fifo[$];

    tfq_pkg::out_item_t pending_outcomes[$];
    directed_row_t      directed_rows[$];

    // Typed expectation travelling with the beat on the input channel
    bit                 beat_known = 1'b0;
    tfq_pkg::out_item_t beat_result = '0;

    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  random_phase = 1'b0;
    bit  long_hold = 1'b0;
    bit  result_taken = 1'b0;
    int  ready_gap = 0;
    int  ready_stretch = 0;
    bit  receiver_idles = 1'b1;
    bit  sender_idles = 1'b1;
    int  sender_stretch = 0;

    three_level_feedback_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TAG_WIDTH(TAG_WIDTH)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic tfq_pkg::out_item_t schedule_tag(tfq_pkg::in_item_t beat);
        tfq_pkg::out_item_t r;
        logic [1:0] lvl;
        r = '0;
        if (beat.mode == tfq_pkg::MODE_ENQUEUE) begin
            if (beat.served_count == 0)
                lvl = tfq_pkg::LEVEL_TOP;
            else if (beat.served_count == 1)
                lvl = tfq_pkg::LEVEL_MIDDLE;
            else
                lvl = tfq_pkg::LEVEL_BOTTOM;
            r.out_level = lvl;
            case (lvl)
                tfq_pkg::LEVEL_TOP: begin
                    if (top_fifo.size() >= QUEUE_DEPTH) r.status = tfq_pkg::STATUS_FULL;
                    else top_fifo.push_back(beat.request_tag);
                end
                tfq_pkg::LEVEL_MIDDLE: begin
                    if (middle_fifo.size() >= QUEUE_DEPTH) r.status = tfq_pkg::STATUS_FULL;
                    else middle_fifo.push_back(beat.request_tag);
                end
                default: begin
                    if (bottom_fifo.size() >= QUEUE_DEPTH) r.status = tfq_pkg::STATUS_FULL;
                    else bottom_fifo.push_back(beat.request_tag);
                end
            endcase
        end else begin
            // Pop from the highest non-empty level
            if (top_fifo.size() != 0) begin
                r.out_tag = top_fifo.pop_front();
                r.out_valid = 1'b1;
                r.out_level = tfq_pkg::LEVEL_TOP;
            end else if (middle_fifo.size() != 0) begin
                r.out_tag = middle_fifo.pop_front();
                r.out_valid = 1'b1;
                r.out_level = tfq_pkg::LEVEL_MIDDLE;
            end else if (bottom_fifo.size() != 0) begin
                r.out_tag = bottom_fifo.pop_front();
                r.out_valid = 1'b1;
                r.out_level = tfq_pkg::LEVEL_BOTTOM;
            end else begin
                r.status = tfq_pkg::STATUS_EMPTY;
            end
        end
        return r;
    endfunction

    function automatic tfq_pkg::out_item_t result_of(logic [tfq_pkg::TAG_BITS-1:0] tag,
                                                     logic valid, logic [1:0] lvl,
                                                     logic [1:0] st);
        tfq_pkg::out_item_t r;
        r.out_tag = tag;
        r.out_valid = valid;
        r.out_level = lvl;
        r.status = st;
        return r;
    endfunction

    function automatic void add_row(logic mode, logic [tfq_pkg::TAG_BITS-1:0] tag,
                                    logic [tfq_pkg::COUNT_BITS-1:0] served, int reps,
                                    bit known, tfq_pkg::out_item_t result);
        directed_row_t row;
        row.beat.mode = mode;
        row.beat.request_tag = tag;
        row.beat.served_count = served;
        row.reps = reps;
        row.known = known;
        row.result = result;
        directed_rows.push_back(row);
    endfunction

    task automatic compare_outcome(tfq_pkg::out_item_t got);
        tfq_pkg::out_item_t want;
        if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("ERROR: unexpected result beat tag=%0h valid=%0b level=%0d status=%0d",
                         got.out_tag, got.out_valid, got.out_level, got.status);
        end else begin
            want = pending_outcomes.pop_front();
            if (got.out_tag !== want.out_tag || got.out_valid !== want.out_valid ||
                got.out_level !== want.out_level || got.status !== want.status) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: expected tag/valid/level/status %0h/%0b/%0d/%0d, got %0h/%0b/%0d/%0d",
                             want.out_tag, want.out_valid, want.out_level, want.status,
                             got.out_tag, got.out_valid, got.out_level, got.status);
            end
        end
    endtask

    // Track accepted beats on both channels in one place
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                tfq_pkg::out_item_t predicted;
                predicted = schedule_tag(s_data);
                pending_outcomes.push_back(beat_known ? beat_result : predicted);
            end
            if (m_valid && m_ready) begin
                compare_outcome(m_data);
                result_taken = 1'b1;
            end
        end
    end

    // Receiver: random stall per beat, in stretches with and without idling
    always @(negedge aclk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            if (ready_stretch == 0) begin
                receiver_idles = ($urandom_range(2, 0) != 0);
                ready_stretch = $urandom_range(40, 5);
            end
            ready_stretch--;
            ready_gap = receiver_idles ? $urandom_range(MAX_GAP, 0) : 0;
        end
        if (long_hold) begin
            m_ready = 1'b0;
        end else if (ready_gap > 0) begin
            m_ready = 1'b0;
            ready_gap--;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Long receiver hold so the block fills and backs up the input
    initial begin
        wait (random_phase);
        repeat (2) begin
            repeat ($urandom_range(400, 50)) @(posedge aclk);
            long_hold = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            long_hold = 1'b0;
        end
    end

    task automatic drive_beat(tfq_pkg::in_item_t beat, bit known,
                              tfq_pkg::out_item_t result);
        int gap;
        if (sender_stretch == 0) begin
            sender_idles = ($urandom_range(2, 0) != 0);
            sender_stretch = $urandom_range(40, 5);
        end
        sender_stretch--;
        gap = sender_idles ? $urandom_range(MAX_GAP, 0) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data = beat;
        beat_known = known;
        beat_result = result;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_outcomes.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [tfq_pkg::COUNT_BITS-1:0] served_for_level(int lvl);
        if (lvl == 0) return tfq_pkg::COUNT_BITS'(0);
        if (lvl == 1) return tfq_pkg::COUNT_BITS'(1);
        return tfq_pkg::COUNT_BITS'($urandom_range(255, 2));
    endfunction

    initial begin
        tfq_pkg::in_item_t beat;
        int issued;
        int len;
        int lvl;

        add_row(tfq_pkg::MODE_DEQUEUE, 8'h00, 8'h00, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_TOP, tfq_pkg::STATUS_EMPTY));
        add_row(tfq_pkg::MODE_ENQUEUE, 8'hFF, 8'h00, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_TOP, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_ENQUEUE, 8'h00, 8'h01, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_MIDDLE, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_ENQUEUE, 8'hA5, 8'hFF, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_BOTTOM, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_ENQUEUE, 8'h5A, 8'h02, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_BOTTOM, tfq_pkg::STATUS_OK));
        // Dequeue ignores tag and count fields
        add_row(tfq_pkg::MODE_DEQUEUE, 8'hFF, 8'hFF, 1, 1'b1,
                result_of(8'hFF, 1'b1, tfq_pkg::LEVEL_TOP, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_DEQUEUE, 8'h00, 8'h00, 1, 1'b1,
                result_of(8'h00, 1'b1, tfq_pkg::LEVEL_MIDDLE, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_DEQUEUE, 8'h0F, 8'h01, 1, 1'b1,
                result_of(8'hA5, 1'b1, tfq_pkg::LEVEL_BOTTOM, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_DEQUEUE, 8'hF0, 8'h02, 1, 1'b1,
                result_of(8'h5A, 1'b1, tfq_pkg::LEVEL_BOTTOM, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_DEQUEUE, 8'h00, 8'h00, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_TOP, tfq_pkg::STATUS_EMPTY));
        // Fill the top level across the pointer wrap, then overflow it
        add_row(tfq_pkg::MODE_ENQUEUE, 8'h10, 8'h00, QUEUE_DEPTH, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_TOP, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_ENQUEUE, 8'hEE, 8'h00, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_TOP, tfq_pkg::STATUS_FULL));
        add_row(tfq_pkg::MODE_ENQUEUE, 8'h33, 8'h01, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_MIDDLE, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_ENQUEUE, 8'h44, 8'h80, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_BOTTOM, tfq_pkg::STATUS_OK));
        add_row(tfq_pkg::MODE_DEQUEUE, 8'h00, 8'h00, QUEUE_DEPTH + 2, 1'b0, '0);
        add_row(tfq_pkg::MODE_DEQUEUE, 8'h00, 8'h00, 1, 1'b1,
                result_of(8'h00, 1'b0, tfq_pkg::LEVEL_TOP, tfq_pkg::STATUS_EMPTY));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            for (int r = 0; r < directed_rows[i].reps; r++) begin
                beat = directed_rows[i].beat;
                beat.request_tag = beat.request_tag + tfq_pkg::TAG_BITS'(r);
                drive_beat(beat, directed_rows[i].known, directed_rows[i].result);
            end
        end
        wait_for_drain();

        random_phase = 1'b1;
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            len = $urandom_range(20, 1);
            case ($urandom_range(9, 0))
                0, 1, 2, 3: begin
                    // Burst into one level, long enough to overflow it at times
                    lvl = $urandom_range(2, 0);
                    repeat (len) begin
                        beat.mode = tfq_pkg::MODE_ENQUEUE;
                        beat.request_tag = tfq_pkg::TAG_BITS'($urandom_range(255, 0));
                        beat.served_count = served_for_level(lvl);
                        drive_beat(beat, 1'b0, '0);
                    end
                end
                4, 5, 6: begin
                    repeat (len) begin
                        beat.mode = tfq_pkg::MODE_DEQUEUE;
                        beat.request_tag = tfq_pkg::TAG_BITS'($urandom_range(255, 0));
                        beat.served_count = tfq_pkg::COUNT_BITS'($urandom_range(255, 0));
                        drive_beat(beat, 1'b0, '0);
                    end
                end
                default: begin
                    repeat (len) begin
                        beat.mode = 1'($urandom_range(1, 0));
                        beat.request_tag = tfq_pkg::TAG_BITS'($urandom_range(255, 0));
                        beat.served_count = served_for_level($urandom_range(2, 0));
                        if ($urandom_range(3, 0) == 0)
                            beat.served_count = tfq_pkg::COUNT_BITS'($urandom_range(255, 0));
                        drive_beat(beat, 1'b0, '0);
                    end
                end
            endcase
            issued += len;
            if ($urandom_range(7, 0) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- three_level_feedback_queue.f -----
rtl/tfq_pkg.sv
rtl/tfq_ram.sv
rtl/three_level_feedback_queue.sv
rtl/tfq_checker.sv
tb/tb_top.sv
